// ===== sv/psg_pkg.sv =====
// psg_pkg: shared types, widths and constants for the tone and noise generator
// no dependencies; imported by the interfaces and every module of the block

package psg_pkg;

  localparam int unsigned NumTones   = 3;
  localparam int unsigned NumChans   = 4;
  localparam int unsigned PeriodW    = 10;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned DataW      = 8;
  localparam int unsigned ShifterW   = 16;

  localparam logic [1:0]          NoiseCh       = 2'd3;
  localparam logic [1:0]          ToneC         = 2'd2;
  localparam logic [ShifterW-1:0] ShifterReset  = 16'h8000;
  localparam logic [LevelW-1:0]   SilentLevel   = 4'd15;

  // noise rate select codes
  localparam logic [1:0] RateFast  = 2'd0;
  localparam logic [1:0] RateMid   = 2'd1;
  localparam logic [1:0] RateSlow  = 2'd2;
  localparam logic [1:0] RateTone2 = 2'd3;

  localparam logic [PeriodW-1:0] ReloadFast = 10'h010;
  localparam logic [PeriodW-1:0] ReloadMid  = 10'h020;
  localparam logic [PeriodW-1:0] ReloadSlow = 10'h040;

  // input action codes
  localparam logic ActTick  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // programmed settings handed from the register file to the generator
  typedef struct packed {
    logic [NumTones-1:0][PeriodW-1:0] periods;
    logic [NumChans-1:0][LevelW-1:0]  volumes;
    logic [PeriodW-1:0]               noise_period;
    logic [1:0]                       rate_sel;
    logic                             white_en;
  } psg_cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] tone_a;
    logic [LevelW-1:0] tone_b;
    logic [LevelW-1:0] tone_c;
    logic [LevelW-1:0] noise;
  } psg_levels_t;

endpackage

// ===== sv/psg_if.sv =====
// psg_in_if and psg_out_if: valid/ready channels of the generator
// depends on psg_pkg for the field widths

interface psg_in_if;
  import psg_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [DataW-1:0] data;

  modport source (output valid, output action, output data, input ready);
  modport sink (input valid, input action, input data, output ready);
endinterface

interface psg_out_if;
  import psg_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] tone_a_level;
  logic [LevelW-1:0] tone_b_level;
  logic [LevelW-1:0] tone_c_level;
  logic [LevelW-1:0] noise_level;

  modport source (output valid, output tone_a_level, output tone_b_level,
                  output tone_c_level, output noise_level, input ready);
  modport sink (input valid, input tone_a_level, input tone_b_level,
                input tone_c_level, input noise_level, output ready);
endinterface

// ===== sv/psg_regs.sv =====
// psg_regs: command byte decoder and programmed register file
// depends on psg_pkg; feeds psg_gen with settings and a shifter reload strobe

module psg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [7:0]            data_i,
  output psg_pkg::psg_cfg_t     cfg_o,
  output logic                  noise_reload_o
);
  import psg_pkg::*;

  psg_cfg_t   cfg_q, cfg_d;
  logic       lat_vol_q, lat_vol_d;
  logic [1:0] lat_ch_q, lat_ch_d;
  logic       noise_reload;

  always_comb begin
    cfg_d        = cfg_q;
    lat_vol_d    = lat_vol_q;
    lat_ch_d     = lat_ch_q;
    noise_reload = 1'b0;
    if (wr_i) begin
      if (data_i[7]) begin
        lat_vol_d = data_i[4];
        lat_ch_d  = data_i[6:5];
        if (data_i[4]) begin
          cfg_d.volumes[data_i[6:5]] = data_i[3:0];
        end else if (data_i[6:5] == NoiseCh) begin
          cfg_d.rate_sel = data_i[1:0];
          cfg_d.white_en = data_i[2];
          noise_reload   = 1'b1;
        end else begin
          cfg_d.periods[data_i[6:5]][3:0] = data_i[3:0];
          if (data_i[6:5] == ToneC) begin
            cfg_d.noise_period = {cfg_q.periods[ToneC][PeriodW-1:4], data_i[3:0]};
          end
        end
      end else if (!lat_vol_q && lat_ch_q != NoiseCh) begin
        // high pitch bits of the latched tone
        cfg_d.periods[lat_ch_q][PeriodW-1:4] = data_i[5:0];
        if (lat_ch_q == ToneC) begin
          cfg_d.noise_period = {data_i[5:0], cfg_q.periods[ToneC][3:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      lat_vol_q <= 1'b0;
      lat_ch_q  <= 2'd0;
    end else begin
      cfg_q     <= cfg_d;
      lat_vol_q <= lat_vol_d;
      lat_ch_q  <= lat_ch_d;
    end
  end

  assign cfg_o          = cfg_q;
  assign noise_reload_o = noise_reload;

endmodule

// ===== sv/psg_gen.sv =====
// psg_gen: tone counters, noise counter and shift register, level mapping
// depends on psg_pkg; settings come from psg_regs

module psg_gen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,
  input  logic                  noise_reload_i,
  input  psg_pkg::psg_cfg_t     cfg_i,
  output psg_pkg::psg_levels_t  levels_o
);
  import psg_pkg::*;

  logic [NumTones-1:0][PeriodW-1:0] cnt_q, cnt_d;
  logic [NumTones-1:0]              phase_q, phase_d;
  logic [PeriodW-1:0]               ncnt_q, ncnt_d;
  logic                             half_q, half_d;
  logic                             nout_q, nout_d;
  logic [ShifterW-1:0]              sh_q, sh_d;
  logic [PeriodW-1:0]               nreload;

  always_comb begin
    case (cfg_i.rate_sel)
      RateFast: nreload = ReloadFast;
      RateMid:  nreload = ReloadMid;
      RateSlow: nreload = ReloadSlow;
      default:  nreload = cfg_i.noise_period;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    ncnt_d  = ncnt_q;
    half_d  = half_q;
    nout_d  = nout_q;
    sh_d    = sh_q;
    if (noise_reload_i) begin
      sh_d = ShifterReset;
    end
    if (tick_i) begin
      for (int i = 0; i < NumTones; i++) begin
        if (cnt_q[i] == '0) begin
          cnt_d[i]   = cfg_i.periods[i];
          phase_d[i] = ~phase_q[i];
        end else begin
          cnt_d[i] = cnt_q[i] - 1'b1;
        end
      end
      if (ncnt_q == '0) begin
        ncnt_d = nreload;
        half_d = ~half_q;
        // shifter steps on every second expiry
        if (!half_q) begin
          nout_d = ~sh_q[0];
          sh_d   = {sh_q[0] ^ (sh_q[3] & cfg_i.white_en), sh_q[ShifterW-1:1]};
        end
      end else begin
        ncnt_d = ncnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= '0;
      ncnt_q  <= '0;
      half_q  <= 1'b0;
      nout_q  <= 1'b0;
      sh_q    <= ShifterReset;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      ncnt_q  <= ncnt_d;
      half_q  <= half_d;
      nout_q  <= nout_d;
      sh_q    <= sh_d;
    end
  end

  // levels follow the state after this tick
  assign levels_o.tone_a = phase_d[0] ? cfg_i.volumes[0] : SilentLevel;
  assign levels_o.tone_b = phase_d[1] ? cfg_i.volumes[1] : SilentLevel;
  assign levels_o.tone_c = phase_d[2] ? cfg_i.volumes[2] : SilentLevel;
  assign levels_o.noise  = nout_d ? cfg_i.volumes[NoiseCh] : SilentLevel;

endmodule

// ===== sv/psg_tone_noise_generator_unit.sv =====
// psg_tone_noise_generator_unit: top level of the three-tone, one-noise generator
// depends on psg_pkg, psg_in_if, psg_out_if, psg_regs and psg_gen
//
// Usage:
//   in_i carries one transaction per item: action 0 is one generator clock
//   tick, action 1 writes the command byte in data. out_o returns
//   one transaction per tick with the four attenuation levels (15 where the
//   channel output is low); writes return nothing.
//   An accepted item waits in the input register and is applied to the state
//   as it leaves it, which also loads a tick's levels into the output
//   register; out_o.valid rises once that output register is loaded.
//   Throughput is one item per cycle while the receiver keeps up, with the
//   counter and shifter update combinational between the two registers.
//   When the receiver stalls, a pending tick holds in the input register and
//   in_i.ready drops; writes still drain while the output waits.
//   Reset clears all counters, periods, volumes and latches, and loads the
//   noise shift register with 0x8000; no transaction is pending afterwards.

module psg_tone_noise_generator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  psg_in_if.sink    in_i,
  psg_out_if.source out_o
);
  import psg_pkg::*;

  logic             s1_valid_q;
  logic             s1_action_q;
  logic [DataW-1:0] s1_data_q;
  logic             out_valid_q;
  psg_levels_t      out_q;
  psg_levels_t      levels;
  psg_cfg_t         cfg;
  logic             noise_reload;
  logic             out_free;
  logic             s1_adv;
  logic             do_tick;
  logic             do_write;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && ((s1_action_q == ActWrite) || out_free);
  assign do_tick  = s1_adv && (s1_action_q == ActTick);
  assign do_write = s1_adv && (s1_action_q == ActWrite);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_action_q <= in_i.action;
      s1_data_q   <= in_i.data;
    end
  end

  psg_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (do_write),
    .data_i         (s1_data_q),
    .cfg_o          (cfg),
    .noise_reload_o (noise_reload)
  );

  psg_gen u_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (do_tick),
    .noise_reload_i (noise_reload),
    .cfg_i          (cfg),
    .levels_o       (levels)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= do_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      out_q <= levels;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tone_a_level = out_q.tone_a;
  assign out_o.tone_b_level = out_q.tone_b;
  assign out_o.tone_c_level = out_q.tone_c;
  assign out_o.noise_level  = out_q.noise;

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for psg_tone_noise_generator_unit, with a directed table
// and random tick/write traffic checked against an in-bench model of the generator
// depends on psg_pkg, psg_in_if, psg_out_if and the generator RTL

module testbench;
  import psg_pkg::*;

  localparam int ItemsPerPhase = 630;
  localparam int StallLimit    = 2000;
  localparam int DrainCycles   = 8;

  localparam logic [1:0]       ToneA     = 2'd0;
  localparam logic [1:0]       ToneB     = 2'd1;
  localparam logic [DataW-1:0] CmdLatch  = 8'h80;
  localparam logic [DataW-1:0] CmdVolume = 8'h10;
  localparam psg_levels_t      NoLevels  = '0;

  typedef struct {
    logic             act;
    logic [DataW-1:0] dat;
    bit               typed;
    psg_levels_t      levels;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  psg_in_if  in_if ();
  psg_out_if out_if ();

  psg_tone_noise_generator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // generator model state
  logic [PeriodW-1:0]  tone_cnt [NumTones];
  logic [PeriodW-1:0]  tone_per [NumTones];
  logic                tone_ph  [NumTones];
  logic [LevelW-1:0]   chan_vol [NumChans];
  logic [PeriodW-1:0]  nz_cnt;
  logic [PeriodW-1:0]  nz_per;
  logic [1:0]          nz_rate;
  logic                nz_white;
  logic [ShifterW-1:0] nz_lfsr;
  logic                nz_half;
  logic                nz_out;
  logic                lat_vol;
  logic [1:0]          lat_ch;

  psg_levels_t levels_q[$];
  stim_row_t   dir_tab[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          n_fail;
  int          quiet_cycles;
  bit          hi_pending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] cmd_byte(logic [1:0] ch, logic is_vol, logic [3:0] low);
    return CmdLatch | {1'b0, ch, 5'b0} | (is_vol ? CmdVolume : 8'h00) | {4'h0, low};
  endfunction

  task automatic gen_reset();
    int i;
    for (i = 0; i < NumTones; i++) begin
      tone_cnt[i] = '0;
      tone_per[i] = '0;
      tone_ph[i]  = 1'b0;
    end
    for (i = 0; i < NumChans; i++) chan_vol[i] = '0;
    nz_cnt   = '0;
    nz_per   = '0;
    nz_rate  = RateFast;
    nz_white = 1'b0;
    nz_lfsr  = ShifterReset;
    nz_half  = 1'b0;
    nz_out   = 1'b0;
    lat_vol  = 1'b0;
    lat_ch   = ToneA;
  endtask

  task automatic gen_write(input logic [DataW-1:0] d);
    if (d[7]) begin
      lat_vol = d[4];
      lat_ch  = d[6:5];
      if (lat_vol) begin
        chan_vol[lat_ch] = d[3:0];
      end else if (lat_ch == NoiseCh) begin
        nz_rate  = d[1:0];
        nz_white = d[2];
        nz_lfsr  = ShifterReset;
      end else begin
        tone_per[lat_ch][3:0] = d[3:0];
        if (lat_ch == ToneC) nz_per = tone_per[ToneC];
      end
    end else if (!lat_vol && lat_ch != NoiseCh) begin
      // high pitch bits, bit 6 dropped
      tone_per[lat_ch][PeriodW-1:4] = d[5:0];
      if (lat_ch == ToneC) nz_per = tone_per[ToneC];
    end
  endtask

  task automatic gen_tick(output psg_levels_t lv);
    int i;
    for (i = 0; i < NumTones; i++) begin
      if (tone_cnt[i] == '0) begin
        tone_cnt[i] = tone_per[i];
        tone_ph[i]  = ~tone_ph[i];
      end else begin
        tone_cnt[i] = tone_cnt[i] - 1'b1;
      end
    end
    if (nz_cnt == '0) begin
      case (nz_rate)
        RateFast: nz_cnt = ReloadFast;
        RateMid:  nz_cnt = ReloadMid;
        RateSlow: nz_cnt = ReloadSlow;
        default:  nz_cnt = nz_per;
      endcase
      nz_half = ~nz_half;
      // shifter only moves on every second expiry
      if (nz_half) begin
        nz_out  = ~nz_lfsr[0];
        nz_lfsr = {nz_lfsr[0] ^ (nz_lfsr[3] & nz_white), nz_lfsr[ShifterW-1:1]};
      end
    end else begin
      nz_cnt = nz_cnt - 1'b1;
    end
    lv.tone_a = tone_ph[0] ? chan_vol[0] : SilentLevel;
    lv.tone_b = tone_ph[1] ? chan_vol[1] : SilentLevel;
    lv.tone_c = tone_ph[2] ? chan_vol[2] : SilentLevel;
    lv.noise  = nz_out ? chan_vol[NoiseCh] : SilentLevel;
  endtask

  task automatic dir_row(input logic act, input logic [DataW-1:0] dat, input bit typed,
                         input psg_levels_t lv);
    stim_row_t row;
    row.act    = act;
    row.dat    = dat;
    row.typed  = typed;
    row.levels = lv;
    dir_tab.push_back(row);
  endtask

  task automatic send_item(input logic act, input logic [DataW-1:0] dat, input bit typed,
                           input psg_levels_t typed_lv);
    psg_levels_t lv;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.data   <= dat;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (act == ActWrite) begin
      gen_write(dat);
    end else begin
      gen_tick(lv);
      levels_q.push_back(typed ? typed_lv : lv);
    end
  endtask

  task automatic rand_item(output logic act, output logic [DataW-1:0] dat);
    int r;
    r   = $urandom_range(0, 99);
    act = ActWrite;
    dat = 8'($urandom);
    if (hi_pending && $urandom_range(0, 3) != 0) begin
      // high pitch bits, mostly small so the tones toggle often
      dat        = {1'b0, 1'($urandom), ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                                     : 6'($urandom_range(0, 1))};
      hi_pending = 1'b0;
    end else if (r < 65) begin
      act = ActTick;
    end else if (r < 73) begin
      dat = cmd_byte(2'($urandom), 1'b1, 4'($urandom));
    end else if (r < 85) begin
      dat        = cmd_byte(2'($urandom_range(0, NumTones - 1)), 1'b0, 4'($urandom));
      hi_pending = 1'b1;
    end else if (r < 90) begin
      dat = cmd_byte(NoiseCh, 1'b0, 4'($urandom));
    end else if (r >= 95) begin
      dat[7] = 1'b0;
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (levels_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [LevelW-1:0] want,
                             input logic [LevelW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin : chk_levels
    psg_levels_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (levels_q.size() == 0) begin
        $error("result transaction with no tick pending");
        n_fail++;
      end else begin
        want = levels_q.pop_front();
        check_field("tone_a_level", want.tone_a, out_if.tone_a_level);
        check_field("tone_b_level", want.tone_b, out_if.tone_b_level);
        check_field("tone_c_level", want.tone_c, out_if.tone_c_level);
        check_field("noise_level", want.noise, out_if.noise_level);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          ph;
    int          k;
    logic        act;
    logic [7:0]  dat;
    rst_ni        = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.action <= ActTick;
    in_if.data   <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_fail        = 0;
    quiet_cycles  = 0;
    hi_pending    = 1'b0;
    gen_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first ticks after reset: all periods zero, so every tone flips each tick
    dir_row(ActTick,  8'h00, 1'b1, '{4'd0, 4'd0, 4'd0, 4'd0});
    dir_row(ActTick,  8'hFF, 1'b1, '{4'd15, 4'd15, 4'd15, 4'd0});
    dir_row(ActWrite, cmd_byte(ToneA, 1'b1, 4'd5), 1'b0, NoLevels);
    dir_row(ActWrite, cmd_byte(ToneB, 1'b1, 4'd10), 1'b0, NoLevels);
    dir_row(ActWrite, cmd_byte(ToneC, 1'b1, 4'd15), 1'b0, NoLevels);
    dir_row(ActWrite, cmd_byte(NoiseCh, 1'b1, 4'd3), 1'b0, NoLevels);
    dir_row(ActTick,  8'h5A, 1'b1, '{4'd5, 4'd10, 4'd15, 4'd3});
    dir_row(ActTick,  8'hA5, 1'b1, '{4'd15, 4'd15, 4'd15, 4'd3});
    // largest tone period
    dir_row(ActWrite, cmd_byte(ToneA, 1'b0, 4'hF), 1'b0, NoLevels);
    dir_row(ActWrite, 8'h3F, 1'b0, NoLevels);
    // bit 6 of a data byte is dropped
    dir_row(ActWrite, cmd_byte(ToneB, 1'b0, 4'h0), 1'b0, NoLevels);
    dir_row(ActWrite, 8'h7F, 1'b0, NoLevels);
    // tone 2 pitch also feeds the noise period
    dir_row(ActWrite, cmd_byte(ToneC, 1'b0, 4'h1), 1'b0, NoLevels);
    dir_row(ActWrite, 8'h00, 1'b0, NoLevels);
    // white noise off tone 2 rate, then a data byte with the noise latched
    dir_row(ActWrite, cmd_byte(NoiseCh, 1'b0, {2'b11, RateTone2}), 1'b0, NoLevels);
    dir_row(ActWrite, 8'h2A, 1'b0, NoLevels);
    dir_row(ActTick,  8'hFF, 1'b0, NoLevels);
    dir_row(ActTick,  8'h00, 1'b0, NoLevels);
    // data byte after a volume latch is dropped
    dir_row(ActWrite, cmd_byte(NoiseCh, 1'b1, 4'hF), 1'b0, NoLevels);
    dir_row(ActWrite, 8'h15, 1'b0, NoLevels);
    dir_row(ActTick,  8'h00, 1'b0, NoLevels);
    // noise control mid-run reloads the shifter and sets the rate, not the noise counter
    dir_row(ActWrite, cmd_byte(NoiseCh, 1'b0, {2'b00, RateMid}), 1'b0, NoLevels);
    dir_row(ActTick,  8'h00, 1'b0, NoLevels);
    dir_row(ActWrite, cmd_byte(NoiseCh, 1'b0, {2'b00, RateSlow}), 1'b0, NoLevels);
    dir_row(ActTick,  8'h00, 1'b0, NoLevels);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].act, dir_tab[k].dat, dir_tab[k].typed, dir_tab[k].levels);
    end

    for (ph = 0; ph < 3; ph++) begin
      // hold the sender back until the pipeline is empty
      drain_results();
      case (ph)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < ItemsPerPhase; k++) begin
        rand_item(act, dat);
        send_item(act, dat, 1'b0, NoLevels);
      end
    end

    in_if.valid <= 1'b0;
    k = 0;
    while (levels_q.size() != 0 && k < StallLimit) begin
      @(posedge clk_i);
      k++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (levels_q.size() != 0) begin
      $error("%0d result transactions never arrived", levels_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
